### hdl/sha1sh_pkg.sv
// Shared types and constants for the SHA-1 stream hasher.
package sha1sh_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_LEN,
        ST_OUT
    } state_t;

    // Initial chaining value, h0 in the top word
    localparam logic [159:0] SHA1_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                        32'h10325476, 32'hC3D2E1F0};

    // Round constants, one per group of 20 rounds
    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    // Round group boundaries and the final round
    localparam logic [6:0] RND_G1   = 7'd20;
    localparam logic [6:0] RND_G2   = 7'd40;
    localparam logic [6:0] RND_G3   = 7'd60;
    localparam logic [6:0] RND_LAST = 7'd79;

    // Block fill positions
    localparam logic [5:0] POS_BLOCK_END = 6'd63;
    localparam logic [5:0] POS_PRE_LEN   = 6'd55;

    // Padding marker byte and index of the last digest byte
    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [4:0] DIG_LAST_IDX = 5'd19;

endpackage

### hdl/sha1_stream_hasher_top.sv
// SHA-1 stream hasher: byte stream in, 20-byte digest out, one shared round unit.
// A message byte is shifted into the block; a byte that fills a 64-byte block starts
// 80 rounds through the single round unit, then one chaining-value add.
// End of message: padding and length bytes are shifted in up to the block end, each padded
// block (one or two) goes through the rounds and the add, then 20 digest transactions follow
// at the pace of m_tready. Input is held off while a block is hashed or the digest goes out.
// Reset (synchronous, aresetn low): idle, chaining value at its initial value, count zero.
module sha1_stream_hasher_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] msg_byte
    input  logic       s_tuser,   // [0] byte_present
    input  logic       s_tlast,   // end_of_message
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] digest_byte
    output logic       m_tlast    // digest_last
);

    sha1sh_pkg::state_t state_reg, state_next;
    sha1sh_pkg::state_t ret_reg, ret_next;
    logic [511:0] blk_reg, blk_next;
    logic [159:0] chain_reg, chain_next;
    logic [159:0] work_reg, work_next;
    logic [63:0]  cnt_reg, cnt_next;
    logic [63:0]  len_reg, len_next;
    logic [6:0]   rnd_reg, rnd_next;
    logic [5:0]   pos_reg, pos_next;
    logic [4:0]   idx_reg, idx_next;
    logic         mark_reg, mark_next;

    logic [31:0] a, b, c, d, e, f, k, w_t, w_new, tmp;
    logic        s_fire, m_fire;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    // Round unit: schedule window taps and one SHA-1 round
    always_comb begin
        a = work_reg[159:128];
        b = work_reg[127:96];
        c = work_reg[95:64];
        d = work_reg[63:32];
        e = work_reg[31:0];
        w_t = blk_reg[511:480];
        w_new = blk_reg[95:64] ^ blk_reg[255:224] ^ blk_reg[447:416] ^ blk_reg[511:480];
        w_new = {w_new[30:0], w_new[31]};
        if (rnd_reg < sha1sh_pkg::RND_G1) begin
            f = (b & c) | (~b & d);
            k = sha1sh_pkg::K_R0;
        end else if (rnd_reg < sha1sh_pkg::RND_G2) begin
            f = b ^ c ^ d;
            k = sha1sh_pkg::K_R1;
        end else if (rnd_reg < sha1sh_pkg::RND_G3) begin
            f = (b & c) | (b & d) | (c & d);
            k = sha1sh_pkg::K_R2;
        end else begin
            f = b ^ c ^ d;
            k = sha1sh_pkg::K_R3;
        end
        tmp = {a[26:0], a[31:27]} + f + e + k + w_t;
    end

    // Handshake outputs
    assign s_tready = (state_reg == sha1sh_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == sha1sh_pkg::ST_OUT);
    assign m_tdata  = chain_reg[159:152];
    assign m_tlast  = (idx_reg == sha1sh_pkg::DIG_LAST_IDX);

    // Sequencer: next state and datapath updates
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        blk_next   = blk_reg;
        chain_next = chain_reg;
        work_next  = chain_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        rnd_next   = rnd_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        mark_next  = mark_reg;
        unique case (state_reg)
            sha1sh_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_tlast) begin
                        mark_next  = 1'b1;
                        state_next = sha1sh_pkg::ST_PAD;
                    end
                    if (s_tuser) begin
                        blk_next = {blk_reg[503:0], s_tdata};
                        cnt_next = cnt_reg + 64'd1;
                        pos_next = pos_reg + 6'd1;
                        if (pos_reg == sha1sh_pkg::POS_BLOCK_END) begin
                            ret_next   = s_tlast ? sha1sh_pkg::ST_PAD : sha1sh_pkg::ST_IDLE;
                            state_next = sha1sh_pkg::ST_ROUND;
                        end
                    end
                end
            end
            sha1sh_pkg::ST_ROUND: begin
                work_next = {tmp, a, {b[1:0], b[31:2]}, c, d};
                blk_next  = {blk_reg[479:0], w_new};
                rnd_next  = rnd_reg + 7'd1;
                if (rnd_reg == sha1sh_pkg::RND_LAST) begin
                    rnd_next   = '0;
                    state_next = sha1sh_pkg::ST_ADD;
                end
            end
            sha1sh_pkg::ST_ADD: begin
                chain_next = {chain_reg[159:128] + work_reg[159:128],
                              chain_reg[127:96]  + work_reg[127:96],
                              chain_reg[95:64]   + work_reg[95:64],
                              chain_reg[63:32]   + work_reg[63:32],
                              chain_reg[31:0]    + work_reg[31:0]};
                state_next = ret_reg;
            end
            sha1sh_pkg::ST_PAD: begin
                // Shift in the marker, then zeros up to the length field
                blk_next  = {blk_reg[503:0], (mark_reg ? sha1sh_pkg::PAD_MARK : 8'h00)};
                mark_next = 1'b0;
                pos_next  = pos_reg + 6'd1;
                if (pos_reg == sha1sh_pkg::POS_BLOCK_END) begin
                    ret_next   = sha1sh_pkg::ST_PAD;
                    state_next = sha1sh_pkg::ST_ROUND;
                end else if (pos_reg == sha1sh_pkg::POS_PRE_LEN) begin
                    len_next   = {cnt_reg[60:0], 3'b000};
                    state_next = sha1sh_pkg::ST_LEN;
                end
            end
            sha1sh_pkg::ST_LEN: begin
                // Shift in the bit count, most significant byte first
                blk_next = {blk_reg[503:0], len_reg[63:56]};
                len_next = {len_reg[55:0], 8'h00};
                pos_next = pos_reg + 6'd1;
                if (pos_reg == sha1sh_pkg::POS_BLOCK_END) begin
                    ret_next   = sha1sh_pkg::ST_OUT;
                    idx_next   = '0;
                    state_next = sha1sh_pkg::ST_ROUND;
                end
            end
            sha1sh_pkg::ST_OUT: begin
                // Advance through the digest one byte per transaction
                if (m_fire) begin
                    chain_next = {chain_reg[151:0], 8'h00};
                    idx_next   = idx_reg + 5'd1;
                    if (idx_reg == sha1sh_pkg::DIG_LAST_IDX) begin
                        chain_next = sha1sh_pkg::SHA1_IV;
                        cnt_next   = '0;
                        idx_next   = '0;
                        state_next = sha1sh_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = sha1sh_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha1sh_pkg::ST_IDLE;
            ret_reg   <= sha1sh_pkg::ST_IDLE;
            chain_reg <= sha1sh_pkg::SHA1_IV;
            cnt_reg   <= '0;
            rnd_reg   <= '0;
            pos_reg   <= '0;
            idx_reg   <= '0;
            mark_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            chain_reg <= chain_next;
            cnt_reg   <= cnt_next;
            rnd_reg   <= rnd_next;
            pos_reg   <= pos_next;
            idx_reg   <= idx_next;
            mark_reg  <= mark_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        blk_reg  <= blk_next;
        work_reg <= work_next;
        len_reg  <= len_next;
    end

endmodule

### hdl/sha1sh_checker.sv
// Port-level checks for the SHA-1 stream hasher, bound to its top level.
module sha1sh_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // Input is held off while the digest is going out
    a_busy_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while digest pending");

    // Accepting the end of a message starts work and drops ready
    a_end_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("ready right after end of message");

    // The last digest byte closes the output
    a_last_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("output valid after last digest byte");

    // A stalled digest transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled digest transaction changed");

endmodule

bind sha1_stream_hasher_top sha1sh_checker u_sha1sh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### verif/sha1_stream_hasher_checker.sv
// Checker for the SHA-1 stream hasher: watches both channels, predicts each digest and compares.
module sha1_stream_hasher_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] msg_byte
    input  logic       s_tuser,   // [0] byte_present
    input  logic       s_tlast,   // end_of_message
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [7:0] digest_byte
    input  logic       m_tlast,   // digest_last
    output int         err_count,
    output int         pending,
    output int         msg_count,
    output int         result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [159:0] H_INIT   = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                         32'h10325476, 32'hC3D2E1F0};
    localparam logic [7:0]   PAD_BYTE = 8'h80;
    localparam int           DIGEST_BYTES = 20;
    localparam int           PRINT_CAP    = 40;

    typedef struct packed {
        logic [7:0] digest_byte;
        logic       digest_last;
    } digest_item_t;

    // Predicted hasher state
    logic [31:0]  hash_h [5];
    logic [7:0]   blk_bytes [64];
    logic [63:0]  byte_cnt;
    digest_item_t digest_expect_q [$];

    initial begin
        err_count    = 0;
        pending      = 0;
        msg_count    = 0;
        result_count = 0;
    end

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Return to the initial chaining value with an empty count
    function automatic void restart_message();
        int i;
        for (i = 0; i < 5; i++) hash_h[i] = H_INIT[159 - 32 * i -: 32];
        for (i = 0; i < 64; i++) blk_bytes[i] = '0;
        byte_cnt = '0;
    endfunction

    // Run the 80 rounds over the current block and fold into the chaining value
    function automatic void sha1_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        int t;
        for (t = 0; t < 16; t++)
            w[t] = {blk_bytes[4 * t], blk_bytes[4 * t + 1], blk_bytes[4 * t + 2],
                    blk_bytes[4 * t + 3]};
        for (t = 16; t < 80; t++)
            w[t] = rotl(w[t - 3] ^ w[t - 8] ^ w[t - 14] ^ w[t - 16], 1);
        a = hash_h[0];
        b = hash_h[1];
        c = hash_h[2];
        d = hash_h[3];
        e = hash_h[4];
        for (t = 0; t < 80; t++) begin
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            tmp = rotl(a, 5) + f + e + k + w[t];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = tmp;
        end
        hash_h[0] += a;
        hash_h[1] += b;
        hash_h[2] += c;
        hash_h[3] += d;
        hash_h[4] += e;
    endfunction

    // Take one input transaction; on end of message pad, finish and queue the digest
    function automatic void absorb_item(input logic [7:0] data, input logic present,
                                        input logic last);
        int pos;
        int i;
        logic [63:0] bit_len;
        digest_item_t item;
        if (present) begin
            blk_bytes[byte_cnt[5:0]] = data;
            byte_cnt++;
            if (byte_cnt[5:0] == 6'd0) sha1_compress();
        end
        if (!last) return;

        pos = int'(byte_cnt[5:0]);
        blk_bytes[pos] = PAD_BYTE;
        for (i = pos + 1; i < 64; i++) blk_bytes[i] = '0;
        // No room for the length field: spill into one more block
        if (pos >= 56) begin
            sha1_compress();
            for (i = 0; i < 64; i++) blk_bytes[i] = '0;
        end
        bit_len = byte_cnt << 3;
        for (i = 0; i < 8; i++) blk_bytes[56 + i] = bit_len[63 - 8 * i -: 8];
        sha1_compress();

        for (i = 0; i < DIGEST_BYTES; i++) begin
            item.digest_byte = hash_h[i / 4][31 - 8 * (i % 4) -: 8];
            item.digest_last = (i == DIGEST_BYTES - 1);
            digest_expect_q.push_back(item);
        end
        msg_count++;
        restart_message();
    endfunction

    // Compare one digest transaction against the oldest expectation
    function automatic void check_digest_byte(input logic [7:0] data, input logic last);
        digest_item_t exp_item;
        result_count++;
        if (digest_expect_q.size() == 0) begin
            if (err_count < PRINT_CAP)
                $display("%0t ns: unexpected digest transaction, expected none, actual %02h last %0b",
                         $time, data, last);
            err_count++;
            return;
        end
        exp_item = digest_expect_q.pop_front();
        if (data !== exp_item.digest_byte) begin
            if (err_count < PRINT_CAP)
                $display("%0t ns: digest_byte mismatch, expected %02h, actual %02h",
                         $time, exp_item.digest_byte, data);
            err_count++;
        end
        if (last !== exp_item.digest_last) begin
            if (err_count < PRINT_CAP)
                $display("%0t ns: digest_last mismatch, expected %0b, actual %0b",
                         $time, exp_item.digest_last, last);
            err_count++;
        end
    endfunction

    // Sample both channels at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_message();
            digest_expect_q.delete();
        end else begin
            if (s_tvalid && s_tready) absorb_item(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready) check_digest_byte(m_tdata, m_tlast);
        end
        pending = digest_expect_q.size();
    end

endmodule

### verif/tb_sha1_stream_hasher_top.sv
// Testbench top for the SHA-1 stream hasher: clock, reset, message stimulus and verdict.
module tb_sha1_stream_hasher_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 250;
    localparam int RANDOM_ITEMS = 140;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    int err_count;
    int pending;
    int msg_count;
    int result_count;

    int send_idle_pct;
    int recv_stall_pct;
    int items_sent;
    int cycle_count;
    int hold_left;
    bit hold_req;

    sha1_stream_hasher_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    sha1_stream_hasher_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .err_count    (err_count),
        .pending      (pending),
        .msg_count    (msg_count),
        .result_count (result_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Digest receiver: random stalls, plus one long hold-off counted here
    initial begin
        m_tready  = 1'b0;
        hold_left = 0;
        hold_req  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Offer one transaction, idling first at random, and hold it until accepted
    task automatic send_item(input logic [7:0] data, input logic present, input logic last);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= present;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (present || last) items_sent++;
    endtask

    // Send a message of random bytes; end either on the last byte or on a bare end item
    task automatic send_message(input int len);
        logic end_on_byte;
        int i;
        end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 11) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Mostly short messages, some around the padding and block boundaries
    function automatic int pick_length();
        if ($urandom_range(0, 9) < 2) begin
            case ($urandom_range(0, 6))
                0: return 0;
                1: return 55;
                2: return 56;
                3: return 57;
                4: return 63;
                5: return 64;
                default: return 65;
            endcase
        end
        return $urandom_range(1, 16);
    endfunction

    initial begin
        int phase;
        int phase_end;
        int base;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        s_tlast        = 1'b0;
        aresetn        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: ignored item, empty message, single bytes, data on a bare end item
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);
        // Short text with an ignored item in the middle
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'hAA, 1'b1, 1'b0);
        send_item(8'h0F, 1'b1, 1'b0);
        send_item(8'hF0, 1'b1, 1'b1);

        // Length field spills into a second padded block
        send_message(56);

        // Random: four idling phases of about equal size
        base = items_sent;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            phase_end = base + (phase + 1) * RANDOM_ITEMS / 4;
            while (items_sent < phase_end) send_message(pick_length());
        end

        // Pressure: hold the receiver off while messages keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b1;
        repeat (3) send_message($urandom_range(1, 8));

        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Drain outstanding digests, then watch for strays
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Covered %0d messages over %0d input transactions, %0d digest bytes checked",
                 msg_count, items_sent, result_count);
        $display("Idling: none, sender 63%%, receiver 63%%, both 37%%, one %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sha1_stream_hasher_top.f
hdl/sha1sh_pkg.sv
hdl/sha1_stream_hasher_top.sv
hdl/sha1sh_checker.sv
verif/sha1_stream_hasher_checker.sv
verif/tb_sha1_stream_hasher_top.sv
